// ----- hw/rtl/fwpsc_pkg.sv -----
// ----------------------------------------------------------------------------
// fwpsc_pkg
// Shared types, constants and register codes of the wheel speed controller.
// ----------------------------------------------------------------------------
package fwpsc_pkg;
	localparam int NumWheels = 4;
	localparam int PosWidth  = 32;

	typedef enum logic [2:0] {
		REG_PROP_GAIN  = 3'd0,
		REG_INTEG_GAIN = 3'd1,
		REG_INT_LIMIT  = 3'd2,
		REG_ROT_GAIN   = 3'd3,
		REG_INV_MASK   = 3'd4,
		REG_CPR        = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_STOP  = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_SPARE = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [15:0] kp;
		logic [15:0] ki;
		logic [20:0] limit;
		logic        invert;
	} lane_cfg_t;

	typedef struct packed {
		logic start;
		logic clear;
	} lane_ctl_t;
endpackage

// ----- hw/rtl/fwpsc_divider.sv -----
// ----------------------------------------------------------------------------
// fwpsc_divider
// Radix-2 restoring divider, one quotient bit per cycle, unsigned 51 / 26.
// ----------------------------------------------------------------------------
module fwpsc_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [50:0] dividend,
	input  logic [25:0] divisor,
	output logic        done,
	output logic [50:0] quotient
);
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [50:0] quo_q;
	logic [25:0] div_q;
	logic [26:0] rem_q;
	logic [26:0] trial;

	assign trial    = {rem_q[25:0], quo_q[50]} - {1'b0, div_q};
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd50) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!trial[26]) begin
				rem_q <= trial;
				quo_q <= {quo_q[49:0], 1'b1};
			end else begin
				rem_q <= {rem_q[25:0], quo_q[50]};
				quo_q <= {quo_q[49:0], 1'b0};
			end
		end
	end
endmodule

// ----- hw/rtl/fwpsc_lane.sv -----
// ----------------------------------------------------------------------------
// fwpsc_lane
// One wheel: speed measurement, error, clamped integrator and PI drive.
// ----------------------------------------------------------------------------
module fwpsc_lane (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fwpsc_pkg::lane_ctl_t  ctl,
	input  fwpsc_pkg::lane_cfg_t  cfg,
	input  logic signed [24:0]    target,
	input  logic [31:0]           pos,
	input  logic [9:0]            ms,
	input  logic [25:0]           divisor,
	output logic                  done,
	output logic signed [8:0]     drive,
	output logic signed [15:0]    speed
);
	import fwpsc_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_DIV, S_INT, S_MUL, S_SUM, S_DRV
	} lstate_t;

	lstate_t             state_q;
	logic [31:0]         last_q;
	logic signed [22:0]  integ_q;
	logic                neg_q;
	logic                dstart_q;
	logic [50:0]         dvd_q;
	logic                ddone;
	logic [50:0]         quo;
	logic signed [25:0]  err_q;
	logic signed [42:0]  pterm_q;
	logic signed [39:0]  iterm_q;
	logic signed [52:0]  acc_q;
	logic signed [31:0]  delta;
	logic [31:0]         mag;
	logic signed [52:0]  spd_full;
	logic signed [15:0]  spd_sat;
	logic signed [37:0]  integ_new;
	logic signed [22:0]  lim;
	logic [52:0]         acc_mag;
	logic                acc_big;
	logic [29:0]         qprod;
	logic signed [9:0]   drv_c;

	assign delta = $signed(pos - last_q);
	assign mag   = delta[31] ? 32'(-delta) : 32'(delta);
	assign spd_full = neg_q ? -$signed({2'b0, quo}) : $signed({2'b0, quo});
	assign spd_sat = (spd_full > 53'sd32767) ? 16'sh7fff :
		(spd_full < -53'sd32768) ? 16'sh8000 : spd_full[15:0];
	assign lim = $signed({2'b0, cfg.limit});
	assign integ_new = 38'(integ_q) + 38'(err_q) * 38'($signed({1'b0, ms}));
	assign acc_mag = acc_q[52] ? 53'(-acc_q) : 53'(acc_q);
	// 4096000 = 2^15 * 125; divide by 125 through a reciprocal below 256 * 4096000
	assign acc_big = acc_mag >= 53'd1048576000;
	assign qprod = 30'(acc_mag[29:15]) * 30'd33555;
	assign drv_c = acc_big ? 10'sd255 : $signed({2'b0, qprod[29:22]});

	fwpsc_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart_q),
		.dividend(dvd_q), .divisor(divisor), .done(ddone), .quotient(quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			last_q   <= '0;
			integ_q  <= '0;
			done     <= 1'b0;
			dstart_q <= 1'b0;
		end else begin
			done     <= 1'b0;
			dstart_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (ctl.clear) integ_q <= '0;
					if (ctl.start) begin
						last_q   <= pos;
						neg_q    <= delta[31];
						dvd_q    <= 51'(mag) * 51'd960000;
						dstart_q <= 1'b1;
						state_q  <= S_DIV;
					end
				end
				S_DIV: if (ddone) begin
					speed   <= spd_sat;
					err_q   <= 26'(target) - 26'(spd_sat);
					state_q <= S_INT;
				end
				S_INT: begin
					integ_q <= (integ_new > 38'(lim)) ? lim :
						(integ_new < -38'(lim)) ? -lim : 23'(integ_new);
					pterm_q <= err_q * $signed({1'b0, cfg.kp});
					state_q <= S_MUL;
				end
				S_MUL: begin
					iterm_q <= integ_q * $signed({1'b0, cfg.ki});
					acc_q   <= 53'(pterm_q) * 53'sd1000;
					state_q <= S_SUM;
				end
				S_SUM: begin
					acc_q   <= acc_q + 53'(iterm_q);
					state_q <= S_DRV;
				end
				S_DRV: begin
					drive   <= 9'((acc_q[52] ^ cfg.invert) ? -drv_c : drv_c);
					done    <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- hw/rtl/four_wheel_pi_speed_control.sv -----
// ----------------------------------------------------------------------------
// four_wheel_pi_speed_control
// Mecanum PI speed controller for four wheels, one lane per wheel.
// ----------------------------------------------------------------------------
// A request on the input channel carries the command, body targets, elapsed
// time and four encoder positions. Each request yields one result with four
// drives and four measured speeds. A control tick runs from the accepting
// edge through the lane radix-2 dividers (51 steps) and lane states to a
// valid result, the four lanes in parallel; other commands skip the lanes,
// give zero drives and speeds, and a clear zeroes the integrators. A new
// request is taken only once the previous result is in the output register.
// Input stall is high while a request is in flight or a result waits on a
// stalled receiver; the result holds until taken. Reset restores register
// defaults, clears encoder history and integrators. The user must write
// registers over the APB port while no request is in flight (not enforced).
// ----------------------------------------------------------------------------
module four_wheel_pi_speed_control (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         cmd,
	input  logic signed [15:0] vx_target,
	input  logic signed [15:0] vy_target,
	input  logic signed [15:0] rotation_target,
	input  logic [9:0]         elapsed_ms,
	input  logic signed [31:0] pos_front_left,
	input  logic signed [31:0] pos_front_right,
	input  logic signed [31:0] pos_rear_left,
	input  logic signed [31:0] pos_rear_right,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [8:0]  drive_front_left,
	output logic signed [8:0]  drive_front_right,
	output logic signed [8:0]  drive_rear_left,
	output logic signed [8:0]  drive_rear_right,
	output logic signed [15:0] speed_front_left,
	output logic signed [15:0] speed_front_right,
	output logic signed [15:0] speed_rear_left,
	output logic signed [15:0] speed_rear_right
);
	import fwpsc_pkg::*;

	logic [15:0] kp_q, ki_q, rg_q, cpr_q;
	logic [20:0] lim_q;
	logic [3:0]  inv_q;
	logic        busy_q, stop_q;
	logic        accept, wr;
	logic [3:0]  ldone, ldone_q;
	logic [9:0]  ms_eff;
	logic [15:0] cpr_eff;
	logic [25:0] divisor;
	logic signed [32:0] rot_prod;
	logic signed [24:0] rot, tgt [NumWheels];
	logic [31:0] pos [NumWheels];
	logic signed [8:0]  drv [NumWheels];
	logic signed [15:0] spd [NumWheels];
	lane_ctl_t   ctl;
	logic        tick;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign in_stall = busy_q || (out_valid && out_stall);
	assign accept = in_valid && !in_stall;
	assign tick = cmd_t'(cmd) == CMD_TICK;
	assign ctl.start = accept && tick;
	assign ctl.clear = accept && (cmd_t'(cmd) == CMD_CLEAR);
	assign ms_eff = (elapsed_ms == 10'd0) ? 10'd1 : elapsed_ms;
	assign cpr_eff = (cpr_q == 16'd0) ? 16'd1 : cpr_q;
	assign divisor = 26'(cpr_eff) * 26'(ms_eff);
	assign rot_prod = $signed({1'b0, rg_q}) * rotation_target;
	assign rot = 25'(rot_prod >>> 8);
	assign tgt[0] = 25'(vx_target) + 25'(vy_target) + rot;
	assign tgt[1] = 25'(vx_target) - 25'(vy_target) - rot;
	assign tgt[2] = 25'(vx_target) - 25'(vy_target) + rot;
	assign tgt[3] = 25'(vx_target) + 25'(vy_target) - rot;
	assign pos[0] = pos_front_left;
	assign pos[1] = pos_front_right;
	assign pos[2] = pos_rear_left;
	assign pos[3] = pos_rear_right;

	for (genvar i = 0; i < NumWheels; i++) begin : g_lane
		lane_cfg_t lcfg;
		logic signed [24:0] tgt_q;
		logic [9:0] ms_q;
		logic [25:0] dv_q;
		assign lcfg = '{kp: kp_q, ki: ki_q, limit: lim_q, invert: inv_q[i]};
		always_ff @(posedge clk) begin
			if (ctl.start) begin
				tgt_q <= tgt[i];
				ms_q  <= ms_eff;
				dv_q  <= divisor;
			end
		end
		fwpsc_lane u_lane (
			.clk(clk), .arst_n(arst_n), .ctl(ctl), .cfg(lcfg),
			.target(ctl.start ? tgt[i] : tgt_q), .pos(pos[i]),
			.ms(ctl.start ? ms_eff : ms_q), .divisor(ctl.start ? divisor : dv_q),
			.done(ldone[i]), .drive(drv[i]), .speed(spd[i])
		);
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[4:2]))
			REG_PROP_GAIN:  prdata = 32'(kp_q);
			REG_INTEG_GAIN: prdata = 32'(ki_q);
			REG_INT_LIMIT:  prdata = 32'(lim_q);
			REG_ROT_GAIN:   prdata = 32'(rg_q);
			REG_INV_MASK:   prdata = 32'(inv_q);
			REG_CPR:        prdata = 32'(cpr_q);
			default:        prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q <= 16'd384; ki_q <= 16'd768; lim_q <= 21'd1600000;
			rg_q <= 16'd128; inv_q <= 4'd5; cpr_q <= 16'd480;
			busy_q <= 1'b0; stop_q <= 1'b0; out_valid <= 1'b0; ldone_q <= '0;
		end else begin
			if (wr) begin
				unique case (reg_idx_t'(paddr[4:2]))
					REG_PROP_GAIN:  kp_q  <= pwdata[15:0];
					REG_INTEG_GAIN: ki_q  <= pwdata[15:0];
					REG_INT_LIMIT:  lim_q <= pwdata[20:0];
					REG_ROT_GAIN:   rg_q  <= pwdata[15:0];
					REG_INV_MASK:   inv_q <= pwdata[3:0];
					REG_CPR:        cpr_q <= pwdata[15:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) out_valid <= 1'b0;
			stop_q <= 1'b0;
			if (accept) begin
				busy_q <= 1'b1;
				stop_q <= !tick;
				ldone_q <= '0;
			end else if (busy_q) begin
				ldone_q <= ldone_q | ldone;
				if (stop_q || (&(ldone_q | ldone))) begin
					busy_q    <= 1'b0;
					out_valid <= 1'b1;
					drive_front_left  <= stop_q ? 9'sd0 : drv[0];
					drive_front_right <= stop_q ? 9'sd0 : drv[1];
					drive_rear_left   <= stop_q ? 9'sd0 : drv[2];
					drive_rear_right  <= stop_q ? 9'sd0 : drv[3];
					speed_front_left  <= stop_q ? 16'sd0 : spd[0];
					speed_front_right <= stop_q ? 16'sd0 : spd[1];
					speed_rear_left   <= stop_q ? 16'sd0 : spd[2];
					speed_rear_right  <= stop_q ? 16'sd0 : spd[3];
				end
			end
		end
	end
endmodule
